// ===== hw/rtl/rpp_pkg.sv =====
// Shared constants, types and the arctangent table for the pivot rotator.
`default_nettype none

package rpp_pkg;

   // Field widths and CORDIC depth
   localparam int COORD_WIDTH     = 16;
   localparam int ANGLE_WIDTH     = 16;
   localparam int TRIG_ITERATIONS = 16;

   // Internal fixed-point formats: angle as 32-bit turn fraction, trig in Q30
   localparam int TURN_W      = 32;
   localparam int TRIG_FRAC   = 30;
   localparam int OUT_FRAC    = 24;
   localparam int ROUND_SHIFT = TRIG_FRAC - OUT_FRAC;
   localparam int TRIG_W      = TURN_W - ROUND_SHIFT;
   localparam int DIFF_W      = COORD_WIDTH + 1;
   localparam int PROD_W      = DIFF_W + TRIG_W;
   localparam int SUM_W       = PROD_W + 2;
   localparam int RND_W       = SUM_W - OUT_FRAC;
   localparam int ATAN_IDX_W  = 5;

   // CORDIC gain compensation K in Q30
   localparam logic signed [TURN_W-1:0] CORDIC_GAIN = TURN_W'(652032874);

   // Offset from pivot plus pivot, carried alongside the trig pipeline
   typedef struct packed {
      logic signed [DIFF_W-1:0]      dx;
      logic signed [DIFF_W-1:0]      dy;
      logic signed [COORD_WIDTH-1:0] hx;
      logic signed [COORD_WIDTH-1:0] hy;
   } side_type;

   // Arctangent of 2^-i as a 32-bit turn fraction
   function automatic logic [TURN_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
      logic [TURN_W-1:0] v;
      case (idx)
         5'd0:    v = 32'h2000_0000;
         5'd1:    v = 32'h12E4_051E;
         5'd2:    v = 32'h09FB_385B;
         5'd3:    v = 32'h0511_11D4;
         5'd4:    v = 32'h028B_0D43;
         5'd5:    v = 32'h0145_D7E1;
         5'd6:    v = 32'h00A2_F61E;
         5'd7:    v = 32'h0051_7C55;
         5'd8:    v = 32'h0028_BE53;
         5'd9:    v = 32'h0014_5F2F;
         5'd10:   v = 32'h000A_2F98;
         5'd11:   v = 32'h0005_17CC;
         5'd12:   v = 32'h0002_8BE6;
         5'd13:   v = 32'h0001_45F3;
         5'd14:   v = 32'h0000_A2FA;
         5'd15:   v = 32'h0000_517D;
         5'd16:   v = 32'h0000_28BE;
         5'd17:   v = 32'h0000_145F;
         5'd18:   v = 32'h0000_0A30;
         5'd19:   v = 32'h0000_0518;
         5'd20:   v = 32'h0000_028C;
         5'd21:   v = 32'h0000_0146;
         5'd22:   v = 32'h0000_00A3;
         5'd23:   v = 32'h0000_0051;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/rpp_cordic.sv =====
// Pipelined CORDIC: one iteration per stage, yields cos and sin in Q24.
`default_nettype none

module rpp_cordic (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    in_valid,
   output logic                                    in_ready,
   input  logic [rpp_pkg::ANGLE_WIDTH-1:0]         in_angle,
   input  rpp_pkg::side_type                       in_side,
   output logic                                    out_valid,
   input  logic                                    out_ready,
   output logic signed [rpp_pkg::TRIG_W-1:0]       out_cos,
   output logic signed [rpp_pkg::TRIG_W-1:0]       out_sin,
   output rpp_pkg::side_type                       out_side
);
   import rpp_pkg::*;

   localparam int N = TRIG_ITERATIONS;

   typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_type;

   logic signed [TURN_W-1:0] x_ff    [0:N];
   logic signed [TURN_W-1:0] y_ff    [0:N];
   logic signed [TURN_W-1:0] z_ff    [0:N];
   quad_type                 q_ff    [0:N];
   side_type                 side_ff [0:N];
   logic [N:0]               vld_ff;
   logic [N+1:0]             adv;

   logic [TURN_W-1:0]        turn;
   logic [1:0]               quad_in;
   logic signed [TURN_W-1:0] z0_in;

   logic signed [TURN_W-1:0] cos_full, sin_full;
   logic signed [TURN_W-1:0] cos_rnd, sin_rnd;
   logic signed [TRIG_W-1:0] cos_ff, sin_ff;
   side_type                 oside_ff;
   logic                     ovld_ff;

   // Advance a stage when it is empty or the stage after it advances
   assign adv[N+1] = !ovld_ff || out_ready;
   for (genvar k = 0; k <= N; k++) begin : g_adv
      assign adv[k] = !vld_ff[k] || adv[k+1];
   end
   assign in_ready = adv[0];

   // Split quadrant off the widened angle; residual is its low 30 bits, signed
   assign turn    = {in_angle, {(TURN_W-ANGLE_WIDTH){1'b0}}};
   assign quad_in = turn[TURN_W-1 -: 2] + {1'b0, turn[TURN_W-3]};
   assign z0_in   = TURN_W'(signed'(turn[TURN_W-3:0]));

   // Load first stage with gain-compensated start vector
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv[0]) begin
         vld_ff[0] <= in_valid;
      end
      if (adv[0]) begin
         x_ff[0]    <= CORDIC_GAIN;
         y_ff[0]    <= '0;
         z_ff[0]    <= z0_in;
         q_ff[0]    <= quad_type'(quad_in);
         side_ff[0] <= in_side;
      end
   end

   // One micro-rotation per stage
   for (genvar i = 0; i < N; i++) begin : g_iter
      logic signed [TURN_W-1:0] x_in, y_in, z_in;
      logic signed [TURN_W-1:0] atan_v;

      assign atan_v = signed'(atan_turn(ATAN_IDX_W'(i)));

      always_comb begin
         if (!z_ff[i][TURN_W-1]) begin
            x_in = x_ff[i] - (y_ff[i] >>> i);
            y_in = y_ff[i] + (x_ff[i] >>> i);
            z_in = z_ff[i] - atan_v;
         end else begin
            x_in = x_ff[i] + (y_ff[i] >>> i);
            y_in = y_ff[i] - (x_ff[i] >>> i);
            z_in = z_ff[i] + atan_v;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i+1] <= 1'b0;
         end else if (adv[i+1]) begin
            vld_ff[i+1] <= vld_ff[i];
         end
         if (adv[i+1]) begin
            x_ff[i+1]    <= x_in;
            y_ff[i+1]    <= y_in;
            z_ff[i+1]    <= z_in;
            q_ff[i+1]    <= q_ff[i];
            side_ff[i+1] <= side_ff[i];
         end
      end
   end

   // Map back to the full circle
   always_comb begin
      case (q_ff[N])
         QUAD_1: begin
            cos_full = -y_ff[N];
            sin_full = x_ff[N];
         end
         QUAD_2: begin
            cos_full = -x_ff[N];
            sin_full = -y_ff[N];
         end
         QUAD_3: begin
            cos_full = y_ff[N];
            sin_full = -x_ff[N];
         end
         default: begin
            cos_full = x_ff[N];
            sin_full = y_ff[N];
         end
      endcase
      cos_rnd = cos_full + TURN_W'(1 << (ROUND_SHIFT-1));
      sin_rnd = sin_full + TURN_W'(1 << (ROUND_SHIFT-1));
   end

   // Round Q30 to Q24 into the output register
   always_ff @(posedge clock) begin
      if (reset) begin
         ovld_ff <= 1'b0;
      end else if (adv[N+1]) begin
         ovld_ff <= vld_ff[N];
      end
      if (adv[N+1]) begin
         cos_ff   <= cos_rnd[TURN_W-1:ROUND_SHIFT];
         sin_ff   <= sin_rnd[TURN_W-1:ROUND_SHIFT];
         oside_ff <= side_ff[N];
      end
   end

   assign out_valid = ovld_ff;
   assign out_cos   = cos_ff;
   assign out_sin   = sin_ff;
   assign out_side  = oside_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/rotate_point_about_pivot_core.sv =====
// Top level: rotates a point about a pivot, rounds half up and saturates.
//
//  Channel | Direction | Ports                                         | Handshake
//  req     | in        | point_x, point_y, pivot_x, pivot_y, turn_angle | req_valid/req_ready
//  rsp     | out       | rotated_x, rotated_y, clipped                 | rsp_valid/rsp_ready
//
//  One item per cycle sustained while rsp_ready stays high; the pipeline is one CORDIC
//  stage per iteration plus input, round, multiply, sum and saturate registers.
//  Synchronous active-high reset clears every valid bit; payload is not reset.
//  Each stage advances when empty or when the stage after it advances, so a
//  stalled output only holds items that are queued behind it; bubbles close up.
`default_nettype none

module rotate_point_about_pivot_core (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_ready,
   input  logic signed [rpp_pkg::COORD_WIDTH-1:0]   req_point_x,
   input  logic signed [rpp_pkg::COORD_WIDTH-1:0]   req_point_y,
   input  logic signed [rpp_pkg::COORD_WIDTH-1:0]   req_pivot_x,
   input  logic signed [rpp_pkg::COORD_WIDTH-1:0]   req_pivot_y,
   input  logic [rpp_pkg::ANGLE_WIDTH-1:0]          req_turn_angle,
   output logic                                     rsp_valid,
   input  logic                                     rsp_ready,
   output logic signed [rpp_pkg::COORD_WIDTH-1:0]   rsp_rotated_x,
   output logic signed [rpp_pkg::COORD_WIDTH-1:0]   rsp_rotated_y,
   output logic                                     rsp_clipped
);
   import rpp_pkg::*;

   localparam logic signed [SUM_W-1:0] HALF_OUT = SUM_W'(1) <<< (OUT_FRAC-1);

   side_type                 side_in;
   logic                     trig_valid, trig_ready;
   logic signed [TRIG_W-1:0] trig_cos, trig_sin;
   side_type                 trig_side;

   logic                     adv_mul, adv_sum, adv_out;

   logic                     mul_vld_ff;
   logic signed [PROD_W-1:0] xc_ff, ys_ff, xs_ff, yc_ff;
   logic signed [COORD_WIDTH-1:0] hx_ff, hy_ff;

   logic                     sum_vld_ff;
   logic signed [SUM_W-1:0]  vx_ff, vy_ff;
   logic signed [SUM_W-1:0]  vx_in, vy_in;

   logic [RND_W-1:0]         rx, ry;
   logic                     rx_over, rx_under, ry_over, ry_under;
   logic signed [COORD_WIDTH-1:0] x_in, y_in;
   logic                     clip_in;

   logic                     out_vld_ff;
   logic signed [COORD_WIDTH-1:0] x_ff, y_ff;
   logic                     clip_ff;

   // Offset of the point from the pivot
   assign side_in.dx = DIFF_W'(req_point_x) - DIFF_W'(req_pivot_x);
   assign side_in.dy = DIFF_W'(req_point_y) - DIFF_W'(req_pivot_y);
   assign side_in.hx = req_pivot_x;
   assign side_in.hy = req_pivot_y;

   rpp_cordic u_cordic (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_angle  (req_turn_angle),
      .in_side   (side_in),
      .out_valid (trig_valid),
      .out_ready (trig_ready),
      .out_cos   (trig_cos),
      .out_sin   (trig_sin),
      .out_side  (trig_side)
   );

   // Stage advance chain from the output back
   assign adv_out    = !out_vld_ff || rsp_ready;
   assign adv_sum    = !sum_vld_ff || adv_out;
   assign adv_mul    = !mul_vld_ff || adv_sum;
   assign trig_ready = adv_mul;

   // Four products of the offset with cos and sin
   always_ff @(posedge clock) begin
      if (reset) begin
         mul_vld_ff <= 1'b0;
      end else if (adv_mul) begin
         mul_vld_ff <= trig_valid;
      end
      if (adv_mul) begin
         xc_ff <= trig_side.dx * trig_cos;
         ys_ff <= trig_side.dy * trig_sin;
         xs_ff <= trig_side.dx * trig_sin;
         yc_ff <= trig_side.dy * trig_cos;
         hx_ff <= trig_side.hx;
         hy_ff <= trig_side.hy;
      end
   end

   // Combine products, add pivot back and the rounding half
   assign vx_in = SUM_W'(xc_ff) - SUM_W'(ys_ff) + (SUM_W'(hx_ff) <<< OUT_FRAC) + HALF_OUT;
   assign vy_in = SUM_W'(xs_ff) + SUM_W'(yc_ff) + (SUM_W'(hy_ff) <<< OUT_FRAC) + HALF_OUT;

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_vld_ff <= 1'b0;
      end else if (adv_sum) begin
         sum_vld_ff <= mul_vld_ff;
      end
      if (adv_sum) begin
         vx_ff <= vx_in;
         vy_ff <= vy_in;
      end
   end

   // Drop fraction bits, then saturate when the upper bits disagree with the sign
   always_comb begin
      rx       = vx_ff[SUM_W-1:OUT_FRAC];
      ry       = vy_ff[SUM_W-1:OUT_FRAC];
      rx_over  = !rx[RND_W-1] && (|rx[RND_W-2:COORD_WIDTH-1]);
      rx_under = rx[RND_W-1] && !(&rx[RND_W-2:COORD_WIDTH-1]);
      ry_over  = !ry[RND_W-1] && (|ry[RND_W-2:COORD_WIDTH-1]);
      ry_under = ry[RND_W-1] && !(&ry[RND_W-2:COORD_WIDTH-1]);
      if (rx_over) begin
         x_in = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end else if (rx_under) begin
         x_in = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
         x_in = rx[COORD_WIDTH-1:0];
      end
      if (ry_over) begin
         y_in = {1'b0, {(COORD_WIDTH-1){1'b1}}};
      end else if (ry_under) begin
         y_in = {1'b1, {(COORD_WIDTH-1){1'b0}}};
      end else begin
         y_in = ry[COORD_WIDTH-1:0];
      end
      clip_in = rx_over || rx_under || ry_over || ry_under;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (adv_out) begin
         out_vld_ff <= sum_vld_ff;
      end
      if (adv_out) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         clip_ff <= clip_in;
      end
   end

   assign rsp_valid     = out_vld_ff;
   assign rsp_rotated_x = x_ff;
   assign rsp_rotated_y = y_ff;
   assign rsp_clipped   = clip_ff;

   // A clipped item carries at least one coordinate at a range limit
   a_clip_at_limit: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_clipped) |->
         (rsp_rotated_x == {1'b0, {(COORD_WIDTH-1){1'b1}}} ||
          rsp_rotated_x == {1'b1, {(COORD_WIDTH-1){1'b0}}} ||
          rsp_rotated_y == {1'b0, {(COORD_WIDTH-1){1'b1}}} ||
          rsp_rotated_y == {1'b1, {(COORD_WIDTH-1){1'b0}}}))
      else $error("clipped item without a saturated coordinate");

   // An empty output register means the whole pipeline can advance
   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input held off while output register is empty");

   // No item appears straight out of reset
   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("item present after reset");

endmodule

`default_nettype wire

// ===== verif/rotate_point_about_pivot_core_test.sv =====
// Self-checking testbench for the pivot rotator: random and directed points against a predictor.
`timescale 1ns / 1ps

// One rotated point as it leaves the block
typedef struct packed {
   logic signed [rpp_pkg::COORD_WIDTH-1:0] x;
   logic signed [rpp_pkg::COORD_WIDTH-1:0] y;
   logic                                   clip;
} rotated_point_type;

// Predict each rotation on acceptance, then match results in order
class rotation_scoreboard;
   localparam int CW    = rpp_pkg::COORD_WIDTH;
   localparam int AW    = rpp_pkg::ANGLE_WIDTH;
   localparam int STEPS = rpp_pkg::TRIG_ITERATIONS;

   rotated_point_type pending_rotations[$];
   int unsigned       failures;

   // Arctangent of 2^-i as a 32-bit fraction of a full turn
   static longint arctan_turn [24] = '{
      64'h2000_0000, 64'h12E4_051E, 64'h09FB_385B, 64'h0511_11D4,
      64'h028B_0D43, 64'h0145_D7E1, 64'h00A2_F61E, 64'h0051_7C55,
      64'h0028_BE53, 64'h0014_5F2F, 64'h000A_2F98, 64'h0005_17CC,
      64'h0002_8BE6, 64'h0001_45F3, 64'h0000_A2FA, 64'h0000_517D,
      64'h0000_28BE, 64'h0000_145F, 64'h0000_0A30, 64'h0000_0518,
      64'h0000_028C, 64'h0000_0146, 64'h0000_00A3, 64'h0000_0051};

   function new();
      failures = 0;
   endfunction

   function int unsigned outstanding();
      return pending_rotations.size();
   endfunction

   // Round half up from Q24, then clamp to the coordinate range
   function logic signed [CW-1:0] round_and_clamp(input longint v, inout logic clip);
      longint r;
      longint lo;
      longint hi;
      lo = -(longint'(1) <<< (CW - 1));
      hi = (longint'(1) <<< (CW - 1)) - 1;
      r  = (v + (longint'(1) <<< 23)) >>> 24;
      if (r < lo) begin
         r    = lo;
         clip = 1'b1;
      end
      if (r > hi) begin
         r    = hi;
         clip = 1'b1;
      end
      return CW'(r);
   endfunction

   function rotated_point_type rotate_about_pivot(input logic signed [CW-1:0] px, py, hx, hy,
                                                  input logic [AW-1:0] turn_angle);
      logic [31:0]       turn;
      logic [31:0]       quad;
      logic [31:0]       resid;
      longint            z, cx, sy, xs, ys, c, s, cos_q24, sin_q24, dx, dy, vx, vy;
      rotated_point_type res;
      // split the turn into a quadrant and a residual within plus or minus an eighth
      turn  = 32'(turn_angle) << (32 - AW);
      quad  = ((turn + 32'h2000_0000) >> 30) & 32'd3;
      resid = turn - (quad << 30);
      z     = longint'(signed'(resid));
      cx    = 652032874;
      sy    = 0;
      // CORDIC in Q30, both updates from the previous values
      for (int i = 0; i < STEPS && i < 24; i++) begin
         xs = cx >>> i;
         ys = sy >>> i;
         if (z >= 0) begin
            cx -= ys;
            sy += xs;
            z  -= arctan_turn[i];
         end else begin
            cx += ys;
            sy -= xs;
            z  += arctan_turn[i];
         end
      end
      // fold the quadrant back in
      case (quad[1:0])
         2'd1: begin c = -sy; s = cx;  end
         2'd2: begin c = -cx; s = -sy; end
         2'd3: begin c = sy;  s = -cx; end
         default: begin c = cx; s = sy; end
      endcase
      cos_q24 = (c + 32) >>> 6;
      sin_q24 = (s + 32) >>> 6;
      // rotate the offset and add the pivot back, exactly
      dx = longint'(px) - longint'(hx);
      dy = longint'(py) - longint'(hy);
      vx = dx * cos_q24 - dy * sin_q24 + (longint'(hx) <<< 24);
      vy = dx * sin_q24 + dy * cos_q24 + (longint'(hy) <<< 24);
      res.clip = 1'b0;
      res.x    = round_and_clamp(vx, res.clip);
      res.y    = round_and_clamp(vy, res.clip);
      return res;
   endfunction

   function void note_point(input logic signed [CW-1:0] px, py, hx, hy,
                            input logic [AW-1:0] turn_angle);
      pending_rotations.push_back(rotate_about_pivot(px, py, hx, hy, turn_angle));
   endfunction

   function void check_rotated(input rotated_point_type got);
      rotated_point_type want;
      if (pending_rotations.size() == 0) begin
         $display("%0t: unexpected item: x %0d y %0d clipped %0b",
                  $time, got.x, got.y, got.clip);
         failures++;
         return;
      end
      want = pending_rotations.pop_front();
      if (got.x !== want.x) begin
         $display("%0t: rotated_x expected %0d, got %0d", $time, want.x, got.x);
         failures++;
      end
      if (got.y !== want.y) begin
         $display("%0t: rotated_y expected %0d, got %0d", $time, want.y, got.y);
         failures++;
      end
      if (got.clip !== want.clip) begin
         $display("%0t: clipped expected %0b, got %0b", $time, want.clip, got.clip);
         failures++;
      end
   endfunction
endclass

module rotate_point_about_pivot_core_test;
   localparam int          CW          = rpp_pkg::COORD_WIDTH;
   localparam int          AW          = rpp_pkg::ANGLE_WIDTH;
   localparam int          ITEM_COUNT  = 1350;
   localparam int          CALM_FROM   = 1150;
   localparam int          PAUSE_AT    = 600;
   localparam int          SETTLE      = 40;
   localparam int unsigned CYCLE_LIMIT = 400000;

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_ready;
   logic signed [CW-1:0] req_point_x    = '0;
   logic signed [CW-1:0] req_point_y    = '0;
   logic signed [CW-1:0] req_pivot_x    = '0;
   logic signed [CW-1:0] req_pivot_y    = '0;
   logic [AW-1:0]        req_turn_angle = '0;
   logic                 rsp_valid;
   logic                 rsp_ready      = 1'b0;
   logic signed [CW-1:0] rsp_rotated_x;
   logic signed [CW-1:0] rsp_rotated_y;
   logic                 rsp_clipped;

   rotation_scoreboard board = new();
   bit                 calm = 1'b0;
   int unsigned        cycle_count = 0;

   rotate_point_about_pivot_core dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_point_x    (req_point_x),
      .req_point_y    (req_point_y),
      .req_pivot_x    (req_pivot_x),
      .req_pivot_y    (req_pivot_y),
      .req_turn_angle (req_turn_angle),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_rotated_x  (rsp_rotated_x),
      .rsp_rotated_y  (rsp_rotated_y),
      .rsp_clipped    (rsp_clipped)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Abandon a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timed out with %0d items outstanding", $time, board.outstanding());
         $display("[rotate_point_about_pivot_core] ERROR");
         $finish;
      end
   end

   // Note accepted points and check accepted results
   always @(posedge clock) begin
      rotated_point_type got;
      if (!reset) begin
         if (req_valid && req_ready)
            board.note_point(req_point_x, req_point_y, req_pivot_x, req_pivot_y,
                             req_turn_angle);
         if (rsp_valid && rsp_ready) begin
            got.x    = rsp_rotated_x;
            got.y    = rsp_rotated_y;
            got.clip = rsp_clipped;
            board.check_rotated(got);
         end
      end
   end

   // Receiver: stall in random bursts, always ready once the run calms down
   initial begin
      int unsigned span;
      forever begin
         if (calm) begin
            rsp_ready <= 1'b1;
            @(posedge clock);
         end else if ($urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b1;
            repeat (64) @(posedge clock);
         end else begin
            span = $urandom_range(1, 16);
            rsp_ready <= ($urandom_range(0, 2) != 0);
            repeat (span) @(posedge clock);
         end
      end
   end

   // Present one item and hold it until accepted
   task automatic send_point(input logic signed [CW-1:0] px, py, hx, hy,
                             input logic [AW-1:0] turn_angle);
      req_valid      <= 1'b1;
      req_point_x    <= px;
      req_point_y    <= py;
      req_pivot_x    <= hx;
      req_pivot_y    <= hy;
      req_turn_angle <= turn_angle;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic hold_off(input int unsigned cycles);
      req_valid <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Stop sending until every outstanding rotation has come back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.outstanding() != 0) @(posedge clock);
   endtask

   initial begin
      bit                   gappy;
      int unsigned          kind;
      logic signed [CW-1:0] px, py, hx, hy;
      logic [AW-1:0]        ang;
      gappy = 1'b1;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed: zero angle, quadrant edges, point on pivot, saturation, bit patterns
      send_point(16'sd0, 16'sd0, 16'sd0, 16'sd0, 16'h0000);
      send_point(16'sd100, -16'sd50, 16'sd0, 16'sd0, 16'h0000);
      send_point(16'sd1000, 16'sd0, 16'sd0, 16'sd0, 16'h4000);
      send_point(16'sd1000, 16'sd0, 16'sd0, 16'sd0, 16'h8000);
      send_point(16'sd1000, 16'sd0, 16'sd0, 16'sd0, 16'hC000);
      send_point(16'sd1000, 16'sd500, 16'sd3, -16'sd7, 16'h2000);
      send_point(16'sd1000, 16'sd500, 16'sd3, -16'sd7, 16'h1FFF);
      send_point(16'sd1000, 16'sd500, 16'sd3, -16'sd7, 16'h6000);
      send_point(16'sd1000, 16'sd500, 16'sd3, -16'sd7, 16'hA000);
      send_point(16'sd1000, 16'sd500, 16'sd3, -16'sd7, 16'hE000);
      send_point(16'sd1000, 16'sd500, 16'sd3, -16'sd7, 16'hFFFF);
      send_point(16'sd32767, -16'sd32768, 16'sd32767, -16'sd32768, 16'h1234);
      send_point(-16'sd32768, 16'sd0, 16'sd32767, 16'sd0, 16'h8000);
      send_point(16'sd32767, 16'sd0, -16'sd32768, 16'sd0, 16'h8000);
      send_point(16'sd32767, 16'sd0, -16'sd32768, 16'sd0, 16'h4000);
      send_point(16'sd32767, 16'sd0, -16'sd32768, 16'sd0, 16'hC000);
      send_point(16'sd32767, 16'sd32767, 16'sd32767, 16'sd32767, 16'hFFFF);
      send_point(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768, 16'h0000);
      send_point(16'h5555, 16'hAAAA, 16'hAAAA, 16'h5555, 16'h5555);
      send_point(16'hAAAA, 16'h5555, 16'h5555, 16'hAAAA, 16'hAAAA);
      send_point(-16'sd32768, 16'sd32767, 16'sd32767, -16'sd32768, 16'h4000);
      send_point(16'sd1, 16'sd1, 16'sd0, 16'sd0, 16'h2000);
      wait_for_drain();

      // Random items in several flavours
      for (int n = 0; n < ITEM_COUNT; n++) begin
         if (n == CALM_FROM)
            calm = 1'b1;
         if (n == PAUSE_AT)
            wait_for_drain();
         if (n % 64 == 0)
            gappy = ($urandom_range(0, 1) != 0);
         if (!calm && gappy && $urandom_range(0, 3) == 0)
            hold_off($urandom_range(1, 16));

         px   = CW'($urandom);
         py   = CW'($urandom);
         hx   = CW'($urandom);
         hy   = CW'($urandom);
         ang  = AW'($urandom);
         kind = $urandom_range(0, 9);
         case (kind)
            // point near the pivot
            4, 5: begin
               px = hx + CW'($urandom_range(0, 512)) - 16'sd256;
               py = hy + CW'($urandom_range(0, 512)) - 16'sd256;
            end
            // angle on or just beside a quarter turn
            6: ang = AW'($urandom_range(0, 3) << 14) + AW'($urandom_range(0, 4)) - 16'd2;
            // far from the pivot, likely to saturate
            7: begin
               px = 16'sd32767 - CW'($urandom_range(0, 2000));
               py = -16'sd32768 + CW'($urandom_range(0, 2000));
               hx = -px;
               hy = -py;
            end
            // point on the pivot
            8: begin
               px = hx;
               py = hy;
            end
            // small coordinates
            9: begin
               px = CW'($urandom_range(0, 2048)) - 16'sd1024;
               py = CW'($urandom_range(0, 2048)) - 16'sd1024;
               hx = CW'($urandom_range(0, 2048)) - 16'sd1024;
               hy = CW'($urandom_range(0, 2048)) - 16'sd1024;
            end
            default: ;
         endcase
         send_point(px, py, hx, hy, ang);
      end
      req_valid <= 1'b0;

      // Drain, then allow stray results to show up
      while (board.outstanding() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (board.failures == 0)
         $display("[rotate_point_about_pivot_core] OK");
      else
         $display("[rotate_point_about_pivot_core] ERROR");
      $finish;
   end
endmodule

// ===== sim.f =====
hw/rtl/rpp_pkg.sv
hw/rtl/rpp_cordic.sv
hw/rtl/rotate_point_about_pivot_core.sv
verif/rotate_point_about_pivot_core_test.sv
